>>> rtl/core/sprq_pkg.sv
// Shared types and codes for the sorted priority queue with counts.
`default_nettype none

package sprq_pkg;

  // Action codes; any other code is a plain query.
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEG  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic        [1:0]  action;
    logic        [7:0]  tag_byte;
    logic signed [31:0] number;
    logic signed [31:0] time_key;
  } sprq_req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [4:0]  total_count;
    logic        [4:0]  tag_count;
    logic        [4:0]  smaller_count;
    logic        [4:0]  larger_count;
    logic        [4:0]  earlier_count;
    logic        [4:0]  later_count;
    logic               head_valid;
    logic        [7:0]  head_tag;
    logic signed [31:0] head_number;
    logic signed [31:0] head_time;
  } sprq_rsp_t;

  typedef struct packed {
    logic        [7:0]  tag_byte;
    logic signed [31:0] number;
    logic signed [31:0] time_key;
  } sprq_entry_t;

  typedef struct packed {
    logic clear;
    logic en;
  } sprq_cnt_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/sprq_store.sv
// Entry memory: one write port, one registered read port.
`default_nettype none

module sprq_store
  import sprq_pkg::*;
#(
  parameter int CAPACITY = 16,
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic        clk_i,
  input  wire logic        we_i,
  input  wire logic [PW-1:0] waddr_i,
  input  wire sprq_entry_t wdata_i,
  input  wire logic        re_i,
  input  wire logic [PW-1:0] raddr_i,
  output sprq_entry_t      rdata_o
);

  sprq_entry_t mem_q [CAPACITY];
  sprq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/sprq_count.sv
// Shared compare unit with the five running counters of a scan.
`default_nettype none

module sprq_count
  import sprq_pkg::*;
#(
  parameter int CAPACITY = 16,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sprq_cnt_ctrl_t ctrl_i,
  input  wire sprq_entry_t    entry_i,
  input  wire sprq_req_t      ref_i,
  output logic [CW-1:0]       tag_cnt_o,
  output logic [CW-1:0]       smaller_cnt_o,
  output logic [CW-1:0]       larger_cnt_o,
  output logic [CW-1:0]       earlier_cnt_o,
  output logic [CW-1:0]       later_cnt_o
);

  logic [CW-1:0] tag_q, sm_q, lg_q, er_q, lt_q;
  logic [CW-1:0] tag_d, sm_d, lg_d, er_d, lt_d;

  always_comb begin
    tag_d = tag_q;
    sm_d  = sm_q;
    lg_d  = lg_q;
    er_d  = er_q;
    lt_d  = lt_q;
    if (ctrl_i.clear) begin
      tag_d = '0;
      sm_d  = '0;
      lg_d  = '0;
      er_d  = '0;
      lt_d  = '0;
    end else if (ctrl_i.en) begin
      tag_d = tag_q + CW'(entry_i.tag_byte == ref_i.tag_byte);
      sm_d  = sm_q  + CW'(entry_i.number   <  ref_i.number);
      lg_d  = lg_q  + CW'(entry_i.number   >  ref_i.number);
      er_d  = er_q  + CW'(entry_i.time_key <  ref_i.time_key);
      lt_d  = lt_q  + CW'(entry_i.time_key >  ref_i.time_key);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
      sm_q  <= '0;
      lg_q  <= '0;
      er_q  <= '0;
      lt_q  <= '0;
    end else begin
      tag_q <= tag_d;
      sm_q  <= sm_d;
      lg_q  <= lg_d;
      er_q  <= er_d;
      lt_q  <= lt_d;
    end
  end

  assign tag_cnt_o     = tag_q;
  assign smaller_cnt_o = sm_q;
  assign larger_cnt_o  = lg_q;
  assign earlier_cnt_o = er_q;
  assign later_cnt_o   = lt_q;

endmodule

`default_nettype wire

>>> rtl/core/sorted_priority_queue_with_counts_unit.sv
// Top level of the sorted priority queue with counts: sequencer and state.
//
// Usage: drive req_i and raise start while busy is low; the transaction is
// taken at that clock edge and busy rises on the next cycle. Exactly one
// result follows on rsp_o, marked by result_valid_o for a single cycle; the
// receiver cannot stall it, so sample it when the strobe is high. busy falls
// in the same cycle as the strobe, so a new start may coincide with it.
//
// Entries live in a ring buffer memory in ascending time order, head first.
// A transaction runs through these steps:
//   scan:   one compare per cycle through the shared unit, fed by the single
//           registered read port, over the n entries held (n - 1 for a remove
//           from a non-empty queue, none for an empty one)
//   add:    move later entries up, one read and one write per entry, and
//           write the new entry; a new head is written with no move
//   result: the response is registered and the strobe raised
// A query, remove or rejected add skips the add step; the memory port sets
// the pace. After reset the queue is empty; the memory is not cleared, as
// only entries below the occupancy are ever read.
`default_nettype none

module sorted_priority_queue_with_counts_unit
  import sprq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire sprq_req_t req_i,
  output logic           result_valid_o,
  output sprq_rsp_t      rsp_o
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_SHR  = 6'b000100,
    S_SHW  = 6'b001000,
    S_INS  = 6'b010000,
    S_RESP = 6'b100000
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  occ_q, occ_d;
  logic [PW-1:0]  hptr_q, hptr_d;
  sprq_entry_t    head_q, head_d;
  sprq_req_t      req_q, req_d;
  logic [1:0]     status_q, status_d;
  logic           add_q, add_d;
  logic           rm_q, rm_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic           rd_vld_q, rd_vld_d;
  logic           first_q, first_d;
  sprq_rsp_t      rsp_q, rsp_d;
  logic           rsp_vld_q, rsp_vld_d;

  // Memory and address path
  logic           re, we;
  logic [CW-1:0]  lidx;
  logic [PW:0]    addr_sum;
  logic [PW-1:0]  addr;
  sprq_entry_t    wdata, rdata;

  // Compare unit
  sprq_cnt_ctrl_t cnt_ctrl;
  logic [CW-1:0]  tag_cnt, sm_cnt, lg_cnt, er_cnt, lt_cnt;

  // Map a position in time order onto the ring; lidx never exceeds CAPACITY,
  // so one conditional subtract wraps it. CAPACITY - 1 steps the head back.
  assign addr_sum = {1'b0, hptr_q} + (PW + 1)'(lidx);
  assign addr     = (addr_sum >= (PW + 1)'(CAPACITY)) ?
                    PW'(addr_sum - (PW + 1)'(CAPACITY)) : PW'(addr_sum);

  sprq_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  sprq_count #(
    .CAPACITY (CAPACITY)
  ) u_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (cnt_ctrl),
    .entry_i       (rdata),
    .ref_i         (req_q),
    .tag_cnt_o     (tag_cnt),
    .smaller_cnt_o (sm_cnt),
    .larger_cnt_o  (lg_cnt),
    .earlier_cnt_o (er_cnt),
    .later_cnt_o   (lt_cnt)
  );

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    hptr_d    = hptr_q;
    head_d    = head_q;
    req_d     = req_q;
    status_d  = status_q;
    add_d     = add_q;
    rm_d      = rm_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    rd_vld_d  = 1'b0;
    first_d   = first_q;
    rsp_d     = rsp_q;
    rsp_vld_d = 1'b0;
    re        = 1'b0;
    we        = 1'b0;
    lidx      = idx_q;
    wdata     = rdata;
    cnt_ctrl  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d        = req_i;
          status_d     = ST_OK;
          add_d        = 1'b0;
          rm_d         = 1'b0;
          case (req_i.action)
            ACT_ADD: begin
              if (req_i.number[31] || req_i.time_key[31]) begin
                status_d = ST_NEG;
              end else if (occ_q == CW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                add_d = 1'b1;
              end
            end
            ACT_REMOVE: begin
              rm_d = (occ_q != '0);
            end
            default: begin
            end
          endcase
          // A remove counts over what stays, so skip the head in the scan.
          idx_d        = (req_i.action == ACT_REMOVE && occ_q != '0) ? CW'(1) : '0;
          first_d      = 1'b1;
          cnt_ctrl.clear = 1'b1;
          state_d      = S_SCAN;
        end
      end

      S_SCAN: begin
        cnt_ctrl.en = rd_vld_q;
        if (rd_vld_q && first_q) begin
          first_d = 1'b0;
          if (rm_q) begin
            head_d = rdata;   // second entry becomes the head
          end
        end
        if (idx_q < occ_q) begin
          re       = 1'b1;
          lidx     = idx_q;
          idx_d    = idx_q + CW'(1);
          rd_vld_d = 1'b1;
        end else begin
          lidx = CW'(1);
          if (!rd_vld_q) begin
            if (add_q) begin
              if (occ_q == '0 || req_q.time_key < head_q.time_key) begin
                pos_d   = '0;
                state_d = S_INS;
              end else begin
                pos_d   = (er_cnt == '0) ? CW'(1) : er_cnt;
                idx_d   = occ_q;
                state_d = S_SHR;
              end
            end else if (rm_q) begin
              hptr_d  = addr;
              occ_d   = occ_q - CW'(1);
              state_d = S_RESP;
            end else begin
              state_d = S_RESP;
            end
          end
        end
      end

      S_SHR: begin
        // Fetch the entry below the open slot, or insert once it is reached.
        if (idx_q > pos_q) begin
          re      = 1'b1;
          lidx    = idx_q - CW'(1);
          state_d = S_SHW;
        end else begin
          state_d = S_INS;
        end
      end

      S_SHW: begin
        we      = 1'b1;
        lidx    = idx_q;
        wdata   = rdata;
        idx_d   = idx_q - CW'(1);
        state_d = S_SHR;
      end

      S_INS: begin
        we             = 1'b1;
        wdata.tag_byte = req_q.tag_byte;
        wdata.number   = req_q.number;
        wdata.time_key = req_q.time_key;
        if (pos_q == '0) begin
          lidx   = CW'(CAPACITY - 1);
          hptr_d = addr;
          head_d = wdata;
        end else begin
          lidx = pos_q;
        end
        occ_d   = occ_q + CW'(1);
        state_d = S_RESP;
      end

      S_RESP: begin
        rsp_d.status        = status_q;
        rsp_d.total_count   = 5'(occ_q);
        // The new entry matches its own tag and ties the other references.
        rsp_d.tag_count     = 5'(tag_cnt + CW'(add_q));
        rsp_d.smaller_count = 5'(sm_cnt);
        rsp_d.larger_count  = 5'(lg_cnt);
        rsp_d.earlier_count = 5'(er_cnt);
        rsp_d.later_count   = 5'(lt_cnt);
        rsp_d.head_valid    = (occ_q != '0);
        rsp_d.head_tag      = (occ_q != '0) ? head_q.tag_byte : '0;
        rsp_d.head_number   = (occ_q != '0) ? head_q.number   : '0;
        rsp_d.head_time     = (occ_q != '0) ? head_q.time_key : '0;
        rsp_vld_d           = 1'b1;
        state_d             = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ_q     <= '0;
      hptr_q    <= '0;
      rd_vld_q  <= 1'b0;
      first_q   <= 1'b0;
      rsp_vld_q <= 1'b0;
      add_q     <= 1'b0;
      rm_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      hptr_q    <= hptr_d;
      rd_vld_q  <= rd_vld_d;
      first_q   <= first_d;
      rsp_vld_q <= rsp_vld_d;
      add_q     <= add_d;
      rm_q      <= rm_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    head_q   <= head_d;
    req_q    <= req_d;
    status_q <= status_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    rsp_q    <= rsp_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rsp_vld_q;
  assign rsp_o          = rsp_q;

endmodule

`default_nettype wire
